// ----- design/chip8_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chip8_pkg
// Shared constants, datapath command codes, status struct and helper
// functions for the CHIP-8 execution core.
// ----------------------------------------------------------------------------
package chip8_pkg;

    localparam int MEM_BYTES   = 4096;
    localparam int SCREEN_W    = 64;
    localparam int SCREEN_H    = 32;
    localparam int STACK_DEPTH = 16;

    localparam int ADDR_W = $clog2(MEM_BYTES);
    localparam int ROW_W  = $clog2(SCREEN_H);
    localparam int COL_W  = $clog2(SCREEN_W);
    localparam int LVL_W  = $clog2(STACK_DEPTH + 1);
    localparam int SP_W   = $clog2(STACK_DEPTH);
    localparam int CNT_W  = 5;

    localparam logic [ADDR_W-1:0] PC_START  = 12'h200;
    localparam logic [ADDR_W-1:0] FONT_BASE = 12'h050;

    localparam logic [1:0] MODE_WRITE = 2'd0;
    localparam logic [1:0] MODE_EXEC  = 2'd1;
    localparam logic [1:0] MODE_PIXEL = 2'd2;

    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_UNKNOWN   = 2'd1;
    localparam logic [1:0] ERR_OVERFLOW  = 2'd2;
    localparam logic [1:0] ERR_UNDERFLOW = 2'd3;

    typedef enum logic [4:0] {
        CMD_NOP,
        CMD_LATCH,
        CMD_CLEAR,
        CMD_WRITE,
        CMD_PIX_RD,
        CMD_PIX_GET,
        CMD_FETCH_HI,
        CMD_FETCH_LO,
        CMD_OP_LO,
        CMD_RD_Y,
        CMD_EXEC,
        CMD_DRAW_RD,
        CMD_DRAW_WR,
        CMD_FCLR,
        CMD_BCD,
        CMD_STORE,
        CMD_LOAD_RD,
        CMD_LOAD_WR,
        CMD_RESULT
    } dp_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic cnt_last;
        logic is_draw;
        logic is_fclr;
        logic is_bcd;
        logic is_store;
        logic is_load;
    } dp_status_t;

    // One decimal digit of an 8-bit value: 0 hundreds, 1 tens, 2 ones.
    function automatic logic [7:0] bcd_digit(input logic [7:0] v, input logic [1:0] k);
        logic [1:0]  h;
        logic [7:0]  r;
        logic [15:0] p;
        logic [3:0]  t;
        logic [7:0]  u;
        h = (v >= 8'd200) ? 2'd2 : ((v >= 8'd100) ? 2'd1 : 2'd0);
        r = v - 8'(h * 8'd100);
        p = 16'(r) * 16'd205;
        t = p[14:11];
        u = r - 8'(t * 8'd10);
        case (k)
            2'd0:    bcd_digit = {6'h0, h};
            2'd1:    bcd_digit = {4'h0, t};
            default: bcd_digit = u;
        endcase
    endfunction

    // Place a sprite line on a screen row starting at column x0, wrapping.
    function automatic logic [SCREEN_W-1:0] sprite_row(input logic [7:0] line,
                                                      input logic [COL_W-1:0] x0);
        logic [SCREEN_W-1:0]   s;
        logic [2*SCREEN_W-1:0] d;
        s = '0;
        for (int c = 0; c < 8; c++) begin
            s[c] = line[7-c];
        end
        d = {s, s} << x0;
        sprite_row = d[2*SCREEN_W-1:SCREEN_W];
    endfunction

endpackage

// ----- design/chip8_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chip8_ctrl
// Sequencer: clearing pass, handshakes and per-step command issue.
// ----------------------------------------------------------------------------
module chip8_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [1:0]             s_mode,
    output logic                   m_valid,
    input  logic                   m_ready,
    input  chip8_pkg::dp_status_t  status,
    output chip8_pkg::dp_cmd_t     cmd
);
    import chip8_pkg::*;

    typedef enum logic [17:0] {
        ST_CLEAR    = 18'h00001,
        ST_IDLE     = 18'h00002,
        ST_WRITE    = 18'h00004,
        ST_PIX_RD   = 18'h00008,
        ST_PIX_GET  = 18'h00010,
        ST_FETCH_HI = 18'h00020,
        ST_FETCH_LO = 18'h00040,
        ST_OP_LO    = 18'h00080,
        ST_RD_Y     = 18'h00100,
        ST_EXEC     = 18'h00200,
        ST_DRAW_RD  = 18'h00400,
        ST_DRAW_WR  = 18'h00800,
        ST_FCLR     = 18'h01000,
        ST_BCD      = 18'h02000,
        ST_STORE    = 18'h04000,
        ST_LOAD_RD  = 18'h08000,
        ST_LOAD_WR  = 18'h10000,
        ST_DONE     = 18'h20000
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

    always_comb begin
        state_next   = state_reg;
        cmd          = CMD_NOP;
        m_valid_next = m_valid_reg && !m_ready;
        case (state_reg)
            ST_CLEAR: begin
                cmd = CMD_CLEAR;
                if (status.clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    cmd = CMD_LATCH;
                    if (s_mode == MODE_EXEC) begin
                        state_next = ST_FETCH_HI;
                    end else if (s_mode == MODE_PIXEL) begin
                        state_next = ST_PIX_RD;
                    end else begin
                        state_next = ST_WRITE;
                    end
                end
            end
            ST_WRITE: begin
                cmd        = CMD_WRITE;
                state_next = ST_DONE;
            end
            ST_PIX_RD: begin
                cmd        = CMD_PIX_RD;
                state_next = ST_PIX_GET;
            end
            ST_PIX_GET: begin
                cmd        = CMD_PIX_GET;
                state_next = ST_DONE;
            end
            ST_FETCH_HI: begin
                cmd        = CMD_FETCH_HI;
                state_next = ST_FETCH_LO;
            end
            ST_FETCH_LO: begin
                cmd        = CMD_FETCH_LO;
                state_next = ST_OP_LO;
            end
            ST_OP_LO: begin
                cmd        = CMD_OP_LO;
                state_next = ST_RD_Y;
            end
            ST_RD_Y: begin
                cmd        = CMD_RD_Y;
                state_next = ST_EXEC;
            end
            ST_EXEC: begin
                cmd = CMD_EXEC;
                if (status.is_draw) begin
                    state_next = ST_DRAW_RD;
                end else if (status.is_fclr) begin
                    state_next = ST_FCLR;
                end else if (status.is_bcd) begin
                    state_next = ST_BCD;
                end else if (status.is_store) begin
                    state_next = ST_STORE;
                end else if (status.is_load) begin
                    state_next = ST_LOAD_RD;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_DRAW_RD: begin
                cmd        = CMD_DRAW_RD;
                state_next = ST_DRAW_WR;
            end
            ST_DRAW_WR: begin
                cmd        = CMD_DRAW_WR;
                state_next = status.cnt_last ? ST_DONE : ST_DRAW_RD;
            end
            ST_FCLR: begin
                cmd = CMD_FCLR;
                if (status.cnt_last) begin
                    state_next = ST_DONE;
                end
            end
            ST_BCD: begin
                cmd = CMD_BCD;
                if (status.cnt_last) begin
                    state_next = ST_DONE;
                end
            end
            ST_STORE: begin
                cmd = CMD_STORE;
                if (status.cnt_last) begin
                    state_next = ST_DONE;
                end
            end
            ST_LOAD_RD: begin
                cmd        = CMD_LOAD_RD;
                state_next = ST_LOAD_WR;
            end
            ST_LOAD_WR: begin
                cmd        = CMD_LOAD_WR;
                state_next = status.cnt_last ? ST_DONE : ST_LOAD_RD;
            end
            ST_DONE: begin
                // hold until the result register is free
                if (!m_valid_reg || m_ready) begin
                    cmd          = CMD_RESULT;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    a_state_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot(state_reg))
        else $error("controller state not one-hot");

    a_result_loaded: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && (!m_valid_reg || m_ready))
        |=> (m_valid_reg && state_reg == ST_IDLE))
        else $error("finished step did not present a result");

    a_exec_fetch: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_mode == MODE_EXEC) |=> (state_reg == ST_FETCH_HI))
        else $error("execute transfer did not start a fetch");

endmodule

// ----- design/chip8_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chip8_datapath
// Register file, I, PC, stack, timers, byte memory, screen rows and the
// result register, all driven by one command per cycle.
// ----------------------------------------------------------------------------
module chip8_datapath (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  chip8_pkg::dp_cmd_t     cmd,
    output chip8_pkg::dp_status_t  status,
    input  logic [1:0]             s_mode,
    input  logic [11:0]            s_address,
    input  logic [7:0]             s_data,
    input  logic [15:0]            s_keys,
    input  logic [7:0]             s_random_byte,
    output logic [11:0]            m_program_counter,
    output logic [15:0]            m_opcode_seen,
    output logic                   m_pixel,
    output logic [7:0]             m_flag_register,
    output logic                   m_waiting_key,
    output logic                   m_sound_on,
    output logic [1:0]             m_error
);
    import chip8_pkg::*;

    // latched step inputs
    logic [1:0]        mode_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [7:0]        data_reg;
    logic [15:0]       keys_reg;
    logic [7:0]        rnd_reg;

    // architectural state
    logic [7:0]        v_reg [16];
    logic [ADDR_W-1:0] i_reg;
    logic [ADDR_W-1:0] pc_reg;
    logic [ADDR_W-1:0] stack_reg [STACK_DEPTH];
    logic [LVL_W-1:0]  lvl_reg;
    logic [7:0]        dt_reg;
    logic [7:0]        st_reg;
    logic [7:0]        mem_array [MEM_BYTES];
    logic [SCREEN_W-1:0] frame_array [SCREEN_H];

    // step working registers
    logic [15:0]       op_reg;
    logic [7:0]        a_reg, b_reg;
    logic [7:0]        mem_q;
    logic [SCREEN_W-1:0] row_q;
    logic [ADDR_W-1:0] clr_reg;
    logic [CNT_W-1:0]  cnt_reg, end_reg;
    logic [COL_W-1:0]  x0_reg;
    logic [ROW_W-1:0]  y0_reg;
    logic [1:0]        err_reg;
    logic              wait_reg;
    logic              pix_reg;

    logic [3:0] op_x, op_y, op_n;
    logic [7:0] op_nn;
    logic [ADDR_W-1:0] op_nnn;
    assign op_x   = op_reg[11:8];
    assign op_y   = op_reg[7:4];
    assign op_n   = op_reg[3:0];
    assign op_nn  = op_reg[7:0];
    assign op_nnn = op_reg[11:0];

    // status
    assign status.clr_last = (clr_reg == ADDR_W'(MEM_BYTES - 1));
    assign status.cnt_last = (cnt_reg == end_reg);
    assign status.is_draw  = (op_reg[15:12] == 4'hD) && (op_n != 4'h0);
    assign status.is_fclr  = (op_reg == 16'h00E0);
    assign status.is_bcd   = (op_reg[15:12] == 4'hF) && (op_nn == 8'h33);
    assign status.is_store = (op_reg[15:12] == 4'hF) && (op_nn == 8'h55);
    assign status.is_load  = (op_reg[15:12] == 4'hF) && (op_nn == 8'h65);

    // register file read port
    logic [3:0] rsel;
    logic [7:0] rdata;
    always_comb begin
        case (cmd)
            CMD_RD_Y:  rsel = op_y;
            CMD_STORE: rsel = cnt_reg[3:0];
            default:   rsel = op_x;
        endcase
    end
    assign rdata = v_reg[rsel];

    // byte memory port
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr, mem_raddr, i_off;
    logic [7:0]        mem_wdata;
    assign i_off = i_reg + ADDR_W'(cnt_reg);

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = i_off;
        mem_wdata = rdata;
        mem_raddr = i_off;
        case (cmd)
            CMD_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = 8'h00;
            end
            CMD_WRITE: begin
                mem_we    = (mode_reg == MODE_WRITE);
                mem_waddr = addr_reg;
                mem_wdata = data_reg;
            end
            CMD_FETCH_HI: mem_raddr = pc_reg;
            CMD_FETCH_LO: mem_raddr = pc_reg + ADDR_W'(1);
            CMD_BCD: begin
                mem_we    = 1'b1;
                mem_wdata = bcd_digit(a_reg, cnt_reg[1:0]);
            end
            CMD_STORE: mem_we = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem_array[mem_waddr] <= mem_wdata;
        end
        mem_q <= mem_array[mem_raddr];
    end

    // screen row port
    logic                frame_we;
    logic [ROW_W-1:0]    frame_wrow, frame_rrow, draw_row;
    logic [SCREEN_W-1:0] frame_wdata, sprite_bits;
    logic                collide;
    assign draw_row    = y0_reg + ROW_W'(cnt_reg);
    assign sprite_bits = sprite_row(mem_q, x0_reg);
    assign collide     = |(row_q & sprite_bits);

    always_comb begin
        frame_we    = 1'b0;
        frame_wrow  = draw_row;
        frame_wdata = '0;
        frame_rrow  = draw_row;
        case (cmd)
            CMD_CLEAR: begin
                frame_we   = 1'b1;
                frame_wrow = clr_reg[ROW_W-1:0];
            end
            CMD_FCLR: begin
                frame_we   = 1'b1;
                frame_wrow = cnt_reg[ROW_W-1:0];
            end
            CMD_PIX_RD: frame_rrow = addr_reg[ROW_W+COL_W-1:COL_W];
            CMD_DRAW_WR: begin
                frame_we    = 1'b1;
                frame_wdata = row_q ^ sprite_bits;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (frame_we) begin
            frame_array[frame_wrow] <= frame_wdata;
        end
        row_q <= frame_array[frame_rrow];
    end

    // instruction execution
    logic [ADDR_W-1:0] ex_pc, ex_i, pc_skip;
    logic              ex_vx_we, ex_vf_we, ex_push, ex_wait, ex_f;
    logic [7:0]        ex_vx, ex_vf, ex_dt, ex_st, a0, b0;
    logic [8:0]        ex_sum;
    logic [LVL_W-1:0]  ex_lvl;
    logic [1:0]        ex_err;
    logic [CNT_W-1:0]  ex_end;
    logic              key_hit, key_found;
    logic [3:0]        key_idx;
    logic [10:0]       font_off;

    assign pc_skip  = pc_reg + ADDR_W'(2);
    assign a0       = (op_x == 4'hF) ? 8'h00 : a_reg;
    assign b0       = (op_y == 4'hF) ? 8'h00 : b_reg;
    assign key_hit  = (a_reg < 8'd16) && keys_reg[a_reg[3:0]];
    assign font_off = {1'b0, a_reg, 2'b00} + 11'(a_reg);

    always_comb begin
        key_found = 1'b0;
        key_idx   = 4'h0;
        for (int k = 15; k >= 0; k--) begin
            if (keys_reg[k]) begin
                key_found = 1'b1;
                key_idx   = 4'(k);
            end
        end
    end

    always_comb begin
        ex_pc    = pc_reg;
        ex_i     = i_reg;
        ex_vx_we = 1'b0;
        ex_vx    = a_reg;
        ex_vf_we = 1'b0;
        ex_vf    = 8'h00;
        ex_push  = 1'b0;
        ex_lvl   = lvl_reg;
        ex_dt    = dt_reg;
        ex_st    = st_reg;
        ex_err   = ERR_NONE;
        ex_wait  = 1'b0;
        ex_end   = '0;
        ex_f     = 1'b0;
        ex_sum   = 9'(a0) + 9'(b0);
        case (op_reg[15:12])
            4'h0: begin
                if (op_reg == 16'h00E0) begin
                    ex_end = CNT_W'(SCREEN_H - 1);
                end else if (op_reg == 16'h00EE) begin
                    if (lvl_reg == '0) begin
                        ex_err = ERR_UNDERFLOW;
                    end else begin
                        ex_lvl = lvl_reg - LVL_W'(1);
                        ex_pc  = stack_reg[ex_lvl[SP_W-1:0]];
                    end
                end else begin
                    ex_err = ERR_UNKNOWN;
                end
            end
            4'h1: ex_pc = op_nnn;
            4'h2: begin
                if (lvl_reg >= LVL_W'(STACK_DEPTH)) begin
                    ex_err = ERR_OVERFLOW;
                end else begin
                    ex_push = 1'b1;
                    ex_lvl  = lvl_reg + LVL_W'(1);
                    ex_pc   = op_nnn;
                end
            end
            4'h3: if (a_reg == op_nn) ex_pc = pc_skip;
            4'h4: if (a_reg != op_nn) ex_pc = pc_skip;
            4'h5: if (a_reg == b_reg) ex_pc = pc_skip;
            4'h6: begin
                ex_vx_we = 1'b1;
                ex_vx    = op_nn;
            end
            4'h7: begin
                ex_vx_we = 1'b1;
                ex_vx    = a_reg + op_nn;
            end
            4'h8: begin
                ex_vx_we = 1'b1;
                case (op_n)
                    4'h0: ex_vx = b_reg;
                    4'h1: ex_vx = a_reg | b_reg;
                    4'h2: ex_vx = a_reg & b_reg;
                    4'h3: ex_vx = a_reg ^ b_reg;
                    4'h4: begin
                        ex_vf_we = 1'b1;
                        ex_vf    = {7'h0, ex_sum[8]};
                        ex_vx    = ex_sum[7:0];
                    end
                    4'h5: begin
                        ex_f     = (a0 >= b0);
                        ex_vf_we = 1'b1;
                        ex_vf    = {7'h0, ex_f};
                        ex_vx    = ((op_x == 4'hF) ? {7'h0, ex_f} : a_reg)
                                 - ((op_y == 4'hF) ? {7'h0, ex_f} : b_reg);
                    end
                    4'h6: begin
                        ex_f     = a_reg[0];
                        ex_vf_we = 1'b1;
                        ex_vf    = {7'h0, ex_f};
                        ex_vx    = ((op_x == 4'hF) ? {7'h0, ex_f} : a_reg) >> 1;
                    end
                    4'h7: begin
                        ex_f     = (b0 >= a0);
                        ex_vf_we = 1'b1;
                        ex_vf    = {7'h0, ex_f};
                        ex_vx    = ((op_y == 4'hF) ? {7'h0, ex_f} : b_reg)
                                 - ((op_x == 4'hF) ? {7'h0, ex_f} : a_reg);
                    end
                    4'hE: begin
                        ex_f     = a_reg[7];
                        ex_vf_we = 1'b1;
                        ex_vf    = {7'h0, ex_f};
                        ex_vx    = ((op_x == 4'hF) ? {7'h0, ex_f} : a_reg) << 1;
                    end
                    default: begin
                        ex_vx_we = 1'b0;
                        ex_err   = ERR_UNKNOWN;
                    end
                endcase
            end
            4'h9: if (a_reg != b_reg) ex_pc = pc_skip;
            4'hA: ex_i = op_nnn;
            4'hB: ex_pc = op_nnn + ADDR_W'(v_reg[0]);
            4'hC: begin
                ex_vx_we = 1'b1;
                ex_vx    = rnd_reg & op_nn;
            end
            4'hD: begin
                // clear VF now; coordinates were taken before
                ex_vf_we = 1'b1;
                ex_end   = CNT_W'(op_n) - CNT_W'(1);
            end
            4'hE: begin
                if (op_nn == 8'h9E) begin
                    if (key_hit) ex_pc = pc_skip;
                end else if (op_nn == 8'hA1) begin
                    if (!key_hit) ex_pc = pc_skip;
                end else begin
                    ex_err = ERR_UNKNOWN;
                end
            end
            default: begin
                case (op_nn)
                    8'h07: begin
                        ex_vx_we = 1'b1;
                        ex_vx    = dt_reg;
                    end
                    8'h0A: begin
                        if (key_found) begin
                            ex_vx_we = 1'b1;
                            ex_vx    = {4'h0, key_idx};
                        end else begin
                            ex_pc   = pc_reg - ADDR_W'(2);
                            ex_wait = 1'b1;
                        end
                    end
                    8'h15: ex_dt = a_reg;
                    8'h18: ex_st = a_reg;
                    8'h1E: ex_i = i_reg + ADDR_W'(a_reg);
                    8'h29: ex_i = FONT_BASE + ADDR_W'(font_off);
                    8'h33: ex_end = CNT_W'(2);
                    8'h55: ex_end = CNT_W'(op_x);
                    8'h65: ex_end = CNT_W'(op_x);
                    default: ex_err = ERR_UNKNOWN;
                endcase
            end
        endcase
        if (ex_err == ERR_NONE) begin
            if (ex_dt != 8'h00) ex_dt = ex_dt - 8'd1;
            if (ex_st != 8'h00) ex_st = ex_st - 8'd1;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg  <= PC_START;
            i_reg   <= '0;
            lvl_reg <= '0;
            dt_reg  <= 8'h00;
            st_reg  <= 8'h00;
            clr_reg <= '0;
            for (int r = 0; r < 16; r++) begin
                v_reg[r] <= 8'h00;
            end
        end else begin
            case (cmd)
                CMD_CLEAR: clr_reg <= clr_reg + ADDR_W'(1);
                CMD_OP_LO: pc_reg <= pc_skip;
                CMD_EXEC: begin
                    pc_reg  <= ex_pc;
                    i_reg   <= ex_i;
                    lvl_reg <= ex_lvl;
                    dt_reg  <= ex_dt;
                    st_reg  <= ex_st;
                    if (ex_vf_we) v_reg[15] <= ex_vf;
                    // result register overrides the flag when it is VF
                    if (ex_vx_we) v_reg[op_x] <= ex_vx;
                end
                CMD_DRAW_WR: if (collide) v_reg[15] <= 8'h01;
                CMD_LOAD_WR: v_reg[cnt_reg[3:0]] <= mem_q;
                default: ;
            endcase
        end
    end

    // working and payload registers
    always_ff @(posedge aclk) begin
        if (cmd == CMD_EXEC && ex_push) begin
            stack_reg[lvl_reg[SP_W-1:0]] <= pc_reg;
        end
        case (cmd)
            CMD_LATCH: begin
                mode_reg <= s_mode;
                addr_reg <= s_address;
                data_reg <= s_data;
                keys_reg <= s_keys;
                rnd_reg  <= s_random_byte;
                op_reg   <= 16'h0000;
                err_reg  <= ERR_NONE;
                wait_reg <= 1'b0;
                pix_reg  <= 1'b0;
            end
            CMD_PIX_GET:  pix_reg <= row_q[addr_reg[COL_W-1:0]];
            CMD_FETCH_LO: op_reg[15:8] <= mem_q;
            CMD_OP_LO: begin
                op_reg[7:0] <= mem_q;
                a_reg       <= rdata;
            end
            CMD_RD_Y: b_reg <= rdata;
            CMD_EXEC: begin
                err_reg  <= ex_err;
                wait_reg <= ex_wait;
                end_reg  <= ex_end;
                cnt_reg  <= '0;
                x0_reg   <= a_reg[COL_W-1:0];
                y0_reg   <= b_reg[ROW_W-1:0];
            end
            CMD_DRAW_WR, CMD_FCLR, CMD_BCD, CMD_STORE, CMD_LOAD_WR: begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            CMD_RESULT: begin
                m_program_counter <= pc_reg;
                m_opcode_seen     <= op_reg;
                m_pixel           <= pix_reg;
                m_flag_register   <= v_reg[15];
                m_waiting_key     <= wait_reg;
                m_sound_on        <= (st_reg != 8'h00);
                m_error           <= err_reg;
            end
            default: ;
        endcase
    end

endmodule

// ----- design/chip8_execution_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chip8_execution_core
// CHIP-8 interpreter core: memory write, one-instruction execute and pixel
// read steps over a valid/ready channel pair.
// ----------------------------------------------------------------------------
// Channel   Ports                                  Transfer
// input     s_valid s_ready s_mode .. s_random_byte  s_valid & s_ready
// result    m_valid m_ready m_program_counter ..     m_valid & m_ready
//
// A memory write runs WRITE, a pixel read PIX_RD and PIX_GET, and an
// instruction FETCH_HI to EXEC. DXYN adds a row read and write per sprite
// row, 00E0 clears row by row, FX55, FX33 and FX65 go byte by byte. After
// reset a clearing pass over 4096 addresses zeroes memory and screen; no
// step is taken during it. One step is in flight at a time; a step may
// be taken while the previous result waits, and finishes once it drains.
// ----------------------------------------------------------------------------
module chip8_execution_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_mode,
    input  logic [11:0] s_address,
    input  logic [7:0]  s_data,
    input  logic [15:0] s_keys,
    input  logic [7:0]  s_random_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [11:0] m_program_counter,
    output logic [15:0] m_opcode_seen,
    output logic        m_pixel,
    output logic [7:0]  m_flag_register,
    output logic        m_waiting_key,
    output logic        m_sound_on,
    output logic [1:0]  m_error
);
    import chip8_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    chip8_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_mode  (s_mode),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    chip8_datapath u_datapath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .status            (status),
        .s_mode            (s_mode),
        .s_address         (s_address),
        .s_data            (s_data),
        .s_keys            (s_keys),
        .s_random_byte     (s_random_byte),
        .m_program_counter (m_program_counter),
        .m_opcode_seen     (m_opcode_seen),
        .m_pixel           (m_pixel),
        .m_flag_register   (m_flag_register),
        .m_waiting_key     (m_waiting_key),
        .m_sound_on        (m_sound_on),
        .m_error           (m_error)
    );

endmodule

// ----- tb/chip8_execution_core_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chip8_execution_core_test
// Drives memory writes, instruction steps and pixel reads into the CHIP-8
// core with random idle gaps on both channels, and checks every result
// against an in-bench interpreter with its own copy of the machine state.
// ----------------------------------------------------------------------------
import chip8_pkg::*;

typedef struct packed {
    logic [11:0] pc;
    logic [15:0] op;
    logic        pix;
    logic [7:0]  vf;
    logic        wait_k;
    logic        snd;
    logic [1:0]  err;
} step_out_t;

class chip8_scoreboard;
    logic [7:0]  vreg [16];
    logic [11:0] ireg;
    logic [11:0] pc;
    logic [11:0] stk [STACK_DEPTH];
    int          level;
    logic [7:0]  dly, snd;
    logic [7:0]  mem [MEM_BYTES];
    logic        scr [SCREEN_W*SCREEN_H];
    step_out_t   pending [$];
    int          mismatches;

    function void reset_state();
        foreach (vreg[k]) vreg[k] = '0;
        foreach (mem[k]) mem[k] = '0;
        foreach (scr[k]) scr[k] = 1'b0;
        foreach (stk[k]) stk[k] = '0;
        ireg = '0; pc = PC_START; level = 0; dly = '0; snd = '0;
        mismatches = 0;
    endfunction

    function logic key_down(logic [15:0] keys, logic [7:0] k);
        return (k > 15) ? 1'b0 : keys[k[3:0]];
    endfunction

    function logic [1:0] run_op(logic [15:0] op, logic [15:0] keys, logic [7:0] rnd,
                                output logic wait_k);
        logic [3:0]  x, y, n;
        logic [7:0]  nn, a, b, line;
        logic [8:0]  sum;
        logic [5:0]  x0;
        logic [4:0]  y0;
        int          at;
        x = op[11:8]; y = op[7:4]; n = op[3:0]; nn = op[7:0];
        wait_k = 1'b0;
        case (op[15:12])
            4'h0: begin
                if (op == 16'h00E0) foreach (scr[k]) scr[k] = 1'b0;
                else if (op == 16'h00EE) begin
                    if (level == 0) return ERR_UNDERFLOW;
                    level--;
                    pc = stk[level];
                end else return ERR_UNKNOWN;
            end
            4'h1: pc = op[11:0];
            4'h2: begin
                if (level >= STACK_DEPTH) return ERR_OVERFLOW;
                stk[level] = pc;
                level++;
                pc = op[11:0];
            end
            4'h3: if (vreg[x] == nn) pc += 12'd2;
            4'h4: if (vreg[x] != nn) pc += 12'd2;
            4'h5: if (vreg[x] == vreg[y]) pc += 12'd2;
            4'h6: vreg[x] = nn;
            4'h7: vreg[x] += nn;
            4'h8: begin
                case (n)
                    4'h0: vreg[x] = vreg[y];
                    4'h1: vreg[x] |= vreg[y];
                    4'h2: vreg[x] &= vreg[y];
                    4'h3: vreg[x] ^= vreg[y];
                    4'h4: begin
                        vreg[15] = 8'd0;
                        sum = {1'b0, vreg[x]} + vreg[y];
                        if (sum[8]) vreg[15] = 8'd1;
                        vreg[x] = sum[7:0];
                    end
                    4'h5: begin
                        vreg[15] = 8'd0;
                        if (vreg[x] >= vreg[y]) vreg[15] = 8'd1;
                        vreg[x] = vreg[x] - vreg[y];
                    end
                    4'h6: begin
                        a = vreg[x];
                        vreg[15] = {7'b0, a[0]};
                        vreg[x] = vreg[x] >> 1;
                    end
                    4'h7: begin
                        vreg[15] = 8'd0;
                        if (vreg[y] >= vreg[x]) vreg[15] = 8'd1;
                        vreg[x] = vreg[y] - vreg[x];
                    end
                    4'hE: begin
                        a = vreg[x];
                        vreg[15] = {7'b0, a[7]};
                        vreg[x] = vreg[x] << 1;
                    end
                    default: return ERR_UNKNOWN;
                endcase
            end
            4'h9: if (vreg[x] != vreg[y]) pc += 12'd2;
            4'hA: ireg = op[11:0];
            4'hB: pc = op[11:0] + {4'b0, vreg[0]};
            4'hC: vreg[x] = rnd & nn;
            4'hD: begin
                a = vreg[x]; b = vreg[y];
                x0 = a[5:0]; y0 = b[4:0];
                vreg[15] = 8'd0;
                for (int r = 0; r < n; r++) begin
                    line = mem[12'(ireg + r)];
                    for (int c = 0; c < 8; c++) begin
                        if (line[7-c]) begin
                            at = 5'(y0 + r) * SCREEN_W + 6'(x0 + c);
                            if (scr[at]) vreg[15] = 8'd1;
                            scr[at] ^= 1'b1;
                        end
                    end
                end
            end
            4'hE: begin
                if (nn == 8'h9E) begin
                    if (key_down(keys, vreg[x])) pc += 12'd2;
                end else if (nn == 8'hA1) begin
                    if (!key_down(keys, vreg[x])) pc += 12'd2;
                end else return ERR_UNKNOWN;
            end
            default: begin
                case (nn)
                    8'h07: vreg[x] = dly;
                    8'h0A: begin
                        for (int k = 0; k < 16; k++)
                            if (keys[k]) begin
                                vreg[x] = 8'(k);
                                return ERR_NONE;
                            end
                        pc -= 12'd2;
                        wait_k = 1'b1;
                    end
                    8'h15: dly = vreg[x];
                    8'h18: snd = vreg[x];
                    8'h1E: ireg += {4'b0, vreg[x]};
                    8'h29: ireg = FONT_BASE + 12'(5 * vreg[x]);
                    8'h33: begin
                        a = vreg[x];
                        mem[ireg] = a / 8'd100;
                        mem[12'(ireg + 1)] = (a / 8'd10) % 8'd10;
                        mem[12'(ireg + 2)] = a % 8'd10;
                    end
                    8'h55: for (int k = 0; k <= x; k++) mem[12'(ireg + k)] = vreg[k];
                    8'h65: for (int k = 0; k <= x; k++) vreg[k] = mem[12'(ireg + k)];
                    default: return ERR_UNKNOWN;
                endcase
            end
        endcase
        return ERR_NONE;
    endfunction

    // Note one accepted step and queue its expected result.
    function void note_step(logic [1:0] mode, logic [11:0] addr, logic [7:0] data,
                            logic [15:0] keys, logic [7:0] rnd);
        step_out_t e;
        logic      w;
        e = '0;
        w = 1'b0;
        if (mode == MODE_WRITE) mem[addr] = data;
        else if (mode == MODE_EXEC) begin
            e.op = {mem[pc], mem[12'(pc + 1)]};
            pc += 12'd2;
            e.err = run_op(e.op, keys, rnd, w);
            if (e.err == ERR_NONE) begin
                if (snd != 0) snd--;
                if (dly != 0) dly--;
            end
        end else if (mode == MODE_PIXEL) e.pix = scr[addr[10:0]];
        e.pc = pc; e.vf = vreg[15]; e.wait_k = w; e.snd = (snd != 0);
        pending = {pending, e};
    endfunction

    function void check_result(step_out_t got);
        step_out_t e;
        if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %p", got);
            return;
        end
        e = pending.pop_front();
        if (got !== e) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %p got %p", e, got);
        end
    endfunction
endclass

module chip8_execution_core_test;
    // mode code with no operation of its own
    localparam logic [1:0] MODE_SPARE = 2'd3;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_mode = '0;
    logic [11:0] s_address = '0;
    logic [7:0]  s_data = '0;
    logic [15:0] s_keys = '0;
    logic [7:0]  s_random_byte = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [11:0] m_program_counter;
    logic [15:0] m_opcode_seen;
    logic        m_pixel;
    logic [7:0]  m_flag_register;
    logic        m_waiting_key;
    logic        m_sound_on;
    logic [1:0]  m_error;

    chip8_scoreboard board = new();
    int  idle_pct = 17;
    int  hold_off = 0;
    logic [11:0] load_at;

    chip8_execution_core dut (.*);

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready)
            board.note_step(s_mode, s_address, s_data, s_keys, s_random_byte);
        if (aresetn && m_valid && m_ready)
            board.check_result({m_program_counter, m_opcode_seen, m_pixel,
                                m_flag_register, m_waiting_key, m_sound_on, m_error});
    end

    // Receiver: random stalls, plus a long hold-off on request.
    always @(negedge aclk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_ready <= 1'b0;
        end else
            m_ready <= ($urandom_range(99) >= idle_pct);
    end

    // Leaves valid high after the transfer; the next call replaces the step or drain() drops it.
    task automatic send_step(logic [1:0] mode, logic [11:0] addr, logic [7:0] data,
                             logic [15:0] keys, logic [7:0] rnd);
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_mode <= mode; s_address <= addr; s_data <= data;
        s_keys <= keys; s_random_byte <= rnd;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic poke(logic [15:0] op);
        send_step(MODE_WRITE, load_at, op[15:8], 16'($urandom), 8'($urandom));
        send_step(MODE_WRITE, load_at + 12'd1, op[7:0], 16'($urandom), 8'($urandom));
        load_at += 12'd2;
    endtask

    task automatic run(logic [15:0] keys);
        send_step(MODE_EXEC, 12'($urandom), 8'($urandom), keys, 8'($urandom));
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (board.pending.size() != 0) @(negedge aclk);
    endtask

    function automatic logic [15:0] random_op();
        logic [15:0] op;
        op = 16'($urandom);
        case ($urandom_range(9))
            0: op[15:12] = 4'h8;
            1: op = {4'hF, op[11:8], 8'h07};
            2: op = {4'hF, op[11:8], 8'h1E};
            3: op[15:12] = 4'h6;
            4: op[15:12] = 4'hE;
            5: op = {4'hD, op[11:4], 4'($urandom_range(4))};
            6: op = {4'hF, op[11:8], 8'h33};
            default: ;
        endcase
        return op;
    endfunction

    initial begin
        #50_000_000;
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        logic [15:0] op;
        logic [15:0] dir_ops [$];
        int j;
        board.reset_state();
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        // Directed program: all groups but 1, 2, 7 and B, flag cases, wraps, unknown opcodes.
        dir_ops = '{16'h60FF, 16'h6101, 16'h8014, 16'h8015, 16'h8016, 16'h801E,
                    16'h8017, 16'h8018, 16'hC0F0, 16'hA000, 16'hF029, 16'hF033,
                    16'hAFFF, 16'hD015, 16'hD015, 16'h3001, 16'h4001, 16'h5015,
                    16'h9010, 16'hF0FF, 16'h0123, 16'hE09E, 16'hE0A1, 16'hF30A,
                    16'hF31E};
        load_at = PC_START;
        foreach (dir_ops[k]) poke(dir_ops[k]);
        for (int k = 0; k < dir_ops.size(); k++)
            run(k == 23 ? 16'h0000 : 16'($urandom));
        run(16'h8000);
        send_step(MODE_PIXEL, 12'hFFF, 8'h00, 16'hFFFF, 8'hFF);
        send_step(MODE_SPARE, 12'h000, 8'hFF, 16'h0000, 8'h00);
        drain();
        // Stack faults: 00EE on empty stack, then overflow with self-calls.
        board.pc = board.pc;
        load_at = 12'h300;
        poke(16'h00EE);
        poke(16'h2304);
        poke(16'h2304);
        send_step(MODE_WRITE, 12'h000, 8'h13, 16'h0, 8'h0);
        send_step(MODE_WRITE, 12'h001, 8'h00, 16'h0, 8'h0);
        poke(16'h1000);
        poke(16'h1000);
        // Reach the block by jumping from wherever PC sits: write jump there.
        send_step(MODE_WRITE, board.pc, 8'h13, 16'h0, 8'h0);
        send_step(MODE_WRITE, board.pc + 12'd1, 8'h00, 16'h0, 8'h0);
        drain();
        run(16'h0000); run(16'h0000); run(16'h0000);
        for (int k = 0; k < STACK_DEPTH + 2; k++) run(16'h0000);
        for (int k = 0; k < STACK_DEPTH + 2; k++) begin
            send_step(MODE_WRITE, 12'h304, 8'h00, 16'h0, 8'h0);
            send_step(MODE_WRITE, 12'h305, 8'hEE, 16'h0, 8'h0);
        end
        for (int k = 0; k < STACK_DEPTH + 2; k++) run(16'h0000);
        drain();
        // Random part: load a random program block, then run it.
        for (int blk = 0; blk < 50; blk++) begin
            drain();
            if (blk == 10) begin
                hold_off = 300;
                idle_pct = 0;
            end
            if (blk == 20) idle_pct = 17;
            load_at = board.pc;
            for (j = 0; j < 6; j++) begin
                op = random_op();
                poke(op);
            end
            for (j = 0; j < 6; j++) run(16'($urandom) & 16'($urandom));
            repeat ($urandom_range(3))
                send_step(MODE_PIXEL, 12'($urandom), 8'($urandom),
                          16'($urandom), 8'($urandom));
            send_step(MODE_WRITE, 12'($urandom), 8'($urandom), 16'($urandom),
                      8'($urandom));
        end
        drain();
        repeat (400) @(negedge aclk);
        if (board.mismatches == 0 && board.pending.size() == 0) $display("TB_OK");
        else $display("TB_ERROR");
        $finish;
    end
endmodule
